// ===== rtl/ryuv_pkg.sv =====
package ryuv_pkg;

    // Video-range limits and offsets, 10-bit codes
    localparam int Y_OFFSET = 64;
    localparam int C_OFFSET = 512;
    localparam int Y_MIN    = 64;
    localparam int Y_MAX    = 940;
    localparam int C_MIN    = 64;
    localparam int C_MAX    = 960;

    // Input item: 8-bit RGBA pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity;
    } t_rgba;

    // Output item: 10-bit YUVA 4:4:4 pixel
    typedef struct packed {
        logic [9:0] luma;
        logic [9:0] chroma_blue;
        logic [9:0] chroma_red;
        logic [9:0] alpha_out;
    } t_yuva;

    // Per-stage load enables shared by all lanes
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_lane_ctl;

endpackage

// ===== rtl/ryuv_stream_if.sv =====
interface ryuv_stream_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ryuv_lane.sv =====
module ryuv_lane
    import ryuv_pkg::*;
#(
    parameter int     FRACTION_BITS = 16,
    parameter longint C_R           = 0,
    parameter longint C_G           = 0,
    parameter longint C_B           = 0,
    parameter int     OFFSET        = 0,
    parameter int     LO            = 0,
    parameter int     HI            = 1023
) (
    input  logic       i_clk,
    input  t_lane_ctl  i_ctl,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic [9:0] o_value
);

    // Coefficient magnitude stays below 4 (luma green is the largest),
    // so FRACTION_BITS+2 bits plus sign
    localparam int CW = FRACTION_BITS + 3;
    localparam int PW = CW + 9;
    localparam int AW = FRACTION_BITS + 12;
    localparam int IW = AW - FRACTION_BITS;

    localparam logic signed [CW-1:0] K_R = CW'(C_R);
    localparam logic signed [CW-1:0] K_G = CW'(C_G);
    localparam logic signed [CW-1:0] K_B = CW'(C_B);

    // Offset plus one half, so the final shift rounds half up
    localparam logic signed [AW-1:0] ROUND_K =
        AW'((longint'(OFFSET) << FRACTION_BITS) + (longint'(1) << (FRACTION_BITS - 1)));

    localparam logic signed [IW-1:0] LO_Q = IW'(LO);
    localparam logic signed [IW-1:0] HI_Q = IW'(HI);

    logic signed [PW-1:0] r_p_r, r_p_g, r_p_b;
    logic signed [AW-1:0] r_acc;
    logic signed [IW-1:0] w_q;
    logic [9:0]           r_value;
    logic [9:0]           n_value;

    // Stage 1: one product per channel
    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_p_r <= K_R * $signed({1'b0, i_red});
            r_p_g <= K_G * $signed({1'b0, i_green});
            r_p_b <= K_B * $signed({1'b0, i_blue});
        end
    end

    // Stage 2: sum with offset and rounding half
    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_acc <= AW'(r_p_r) + AW'(r_p_g) + AW'(r_p_b) + ROUND_K;
        end
    end

    // Stage 3: floor and clamp
    assign w_q = r_acc[AW-1:FRACTION_BITS];

    always_comb begin
        if (w_q < LO_Q) begin
            n_value = 10'(LO_Q);
        end else if (w_q > HI_Q) begin
            n_value = 10'(HI_Q);
        end else begin
            n_value = w_q[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// ===== rtl/rgba8_to_yuva444_10bit_bt709_unit.sv =====
// BT.709 RGBA 8-bit to YUVA 4:4:4 10-bit converter, video range for Y/Cb/Cr and
// full range for alpha. One pixel item is taken per clock while input ready is high,
// and results leave in order through the product, sum, round/clamp register stages.
// Elastic pipeline: each stage holds its item while the next one is stalled,
// and input ready drops only once all three stages are full and the output waits.
// FRACTION_BITS (12..24) sets the precision of the fixed-point coefficients.
module rgba8_to_yuva444_10bit_bt709_unit
    import ryuv_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ryuv_stream_if.sink   i_pix,
    ryuv_stream_if.source o_pix
);

    // Fixed-point weights, rounded to nearest
    localparam longint KY_R = ((longint'(2126 * 876) << FRACTION_BITS) + 2550000 / 2)
                              / 2550000;
    localparam longint KY_G = ((longint'(7152 * 876) << FRACTION_BITS) + 2550000 / 2)
                              / 2550000;
    localparam longint KY_B = ((longint'(722 * 876) << FRACTION_BITS) + 2550000 / 2)
                              / 2550000;
    localparam longint KC_HALF = ((longint'(448) << FRACTION_BITS) + 255 / 2) / 255;
    localparam longint KU_R = ((longint'(2126 * 448) << FRACTION_BITS) + (9278 * 255) / 2)
                              / (9278 * 255);
    localparam longint KU_G = ((longint'(7152 * 448) << FRACTION_BITS) + (9278 * 255) / 2)
                              / (9278 * 255);
    localparam longint KV_G = ((longint'(7152 * 448) << FRACTION_BITS) + (7874 * 255) / 2)
                              / (7874 * 255);
    localparam longint KV_B = ((longint'(722 * 448) << FRACTION_BITS) + (7874 * 255) / 2)
                              / (7874 * 255);

    t_lane_ctl  w_ctl;
    logic       r_v1, r_v2, r_v3;
    logic [9:0] r_a1, r_a2, r_a3;
    logic [9:0] w_luma, w_cb, w_cr;
    logic [9:0] w_three_a;
    logic [9:0] w_a_frac;
    logic [1:0] w_a_q;

    // Stage enables: a stage loads when empty or when the next one moves
    assign w_ctl.en3   = !r_v3 || o_pix.ready;
    assign w_ctl.en2   = !r_v2 || w_ctl.en3;
    assign w_ctl.en1   = !r_v1 || w_ctl.en2;
    assign i_pix.ready = w_ctl.en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ctl.en1) begin
                r_v1 <= i_pix.valid;
            end
            if (w_ctl.en2) begin
                r_v2 <= r_v1;
            end
            if (w_ctl.en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Alpha: (a*1023+127)/255 = 4a + (3a+127)/255, quotient 0..3
    assign w_a_frac = 10'({i_pix.data.opacity, 1'b0}) + 10'(i_pix.data.opacity) + 10'd127;

    always_comb begin
        if (w_a_frac >= 10'd765) begin
            w_a_q = 2'd3;
        end else if (w_a_frac >= 10'd510) begin
            w_a_q = 2'd2;
        end else if (w_a_frac >= 10'd255) begin
            w_a_q = 2'd1;
        end else begin
            w_a_q = 2'd0;
        end
    end

    assign w_three_a = {i_pix.data.opacity, 2'b00} + 10'(w_a_q);

    // Alpha rides along the three stages
    always_ff @(posedge i_clk) begin
        if (w_ctl.en1) begin
            r_a1 <= w_three_a;
        end
        if (w_ctl.en2) begin
            r_a2 <= r_a1;
        end
        if (w_ctl.en3) begin
            r_a3 <= r_a2;
        end
    end

    // Luma
    ryuv_lane #(
        .FRACTION_BITS (FRACTION_BITS),
        .C_R           (KY_R),
        .C_G           (KY_G),
        .C_B           (KY_B),
        .OFFSET        (Y_OFFSET),
        .LO            (Y_MIN),
        .HI            (Y_MAX)
    ) u_lane_y (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_red   (i_pix.data.red),
        .i_green (i_pix.data.green),
        .i_blue  (i_pix.data.blue),
        .o_value (w_luma)
    );

    // Blue-difference chroma
    ryuv_lane #(
        .FRACTION_BITS (FRACTION_BITS),
        .C_R           (-KU_R),
        .C_G           (-KU_G),
        .C_B           (KC_HALF),
        .OFFSET        (C_OFFSET),
        .LO            (C_MIN),
        .HI            (C_MAX)
    ) u_lane_cb (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_red   (i_pix.data.red),
        .i_green (i_pix.data.green),
        .i_blue  (i_pix.data.blue),
        .o_value (w_cb)
    );

    // Red-difference chroma
    ryuv_lane #(
        .FRACTION_BITS (FRACTION_BITS),
        .C_R           (KC_HALF),
        .C_G           (-KV_G),
        .C_B           (-KV_B),
        .OFFSET        (C_OFFSET),
        .LO            (C_MIN),
        .HI            (C_MAX)
    ) u_lane_cr (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_red   (i_pix.data.red),
        .i_green (i_pix.data.green),
        .i_blue  (i_pix.data.blue),
        .o_value (w_cr)
    );

    // Output item
    assign o_pix.valid            = r_v3;
    assign o_pix.data.luma        = w_luma;
    assign o_pix.data.chroma_blue = w_cb;
    assign o_pix.data.chroma_red  = w_cr;
    assign o_pix.data.alpha_out   = r_a3;

endmodule

// ===== tb/bt709_pixel_checker.sv =====
`timescale 1ns / 1ps

module bt709_pixel_checker
    import ryuv_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_pix_valid,
    input  logic  i_pix_ready,
    input  t_rgba i_pix_data,
    input  logic  i_yuv_valid,
    input  logic  i_yuv_ready,
    input  t_yuva i_yuv_data,
    output int    o_fail_count,
    output int    o_pending
);

    // Fixed-point weights, rounded to nearest
    longint y_wr, y_wg, y_wb;
    longint cb_wr, cb_wg, cb_wb;
    longint cr_wr, cr_wg, cr_wb;

    t_yuva expected_yuva_q[$];

    function automatic longint fixed_weight(longint unsigned num, longint unsigned den,
                                            bit neg);
        longint unsigned mag;
        mag = ((num << FRACTION_BITS) + den / 2) / den;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // Add offset and half LSB, floor, then clamp to [lo, hi]
    function automatic logic [9:0] round_clamp(longint offset, longint acc,
                                               longint lo, longint hi);
        longint total;
        longint v;
        total = (offset <<< FRACTION_BITS) + acc + (longint'(1) <<< (FRACTION_BITS - 1));
        if (total < 0)
            return lo[9:0];
        v = total >>> FRACTION_BITS;
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v[9:0];
    endfunction

    function automatic t_yuva predict_yuva(t_rgba px);
        t_yuva  res;
        longint r, g, b;
        int     a;
        r = longint'(px.red);
        g = longint'(px.green);
        b = longint'(px.blue);
        a = int'(px.opacity);
        res.luma        = round_clamp(Y_OFFSET, y_wr * r + y_wg * g + y_wb * b, Y_MIN, Y_MAX);
        res.chroma_blue = round_clamp(C_OFFSET, cb_wr * r + cb_wg * g + cb_wb * b,
                                      C_MIN, C_MAX);
        res.chroma_red  = round_clamp(C_OFFSET, cr_wr * r + cr_wg * g + cr_wb * b,
                                      C_MIN, C_MAX);
        res.alpha_out   = 10'((a * 1023 + 127) / 255);
        return res;
    endfunction

    function automatic int field_differs(string name, logic [9:0] exp_v, logic [9:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    initial begin
        y_wr  = fixed_weight(2126 * 876, 2550000, 1'b0);
        y_wg  = fixed_weight(7152 * 876, 2550000, 1'b0);
        y_wb  = fixed_weight(722 * 876, 2550000, 1'b0);
        cb_wr = fixed_weight(2126 * 448, 9278 * 255, 1'b1);
        cb_wg = fixed_weight(7152 * 448, 9278 * 255, 1'b1);
        cb_wb = fixed_weight(448, 255, 1'b0);
        cr_wr = fixed_weight(448, 255, 1'b0);
        cr_wg = fixed_weight(7152 * 448, 7874 * 255, 1'b1);
        cr_wb = fixed_weight(722 * 448, 7874 * 255, 1'b1);
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Record accepted pixels, compare results in order
    always @(posedge i_clk) begin
        t_yuva exp_px;
        int    errs;
        if (i_rst_n) begin
            if (i_pix_valid && i_pix_ready)
                expected_yuva_q.push_back(predict_yuva(i_pix_data));
            if (i_yuv_valid && i_yuv_ready) begin
                if (expected_yuva_q.size() == 0) begin
                    $error("unexpected result: luma %0d cb %0d cr %0d alpha %0d",
                           i_yuv_data.luma, i_yuv_data.chroma_blue,
                           i_yuv_data.chroma_red, i_yuv_data.alpha_out);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_px = expected_yuva_q.pop_front();
                    errs = field_differs("luma", exp_px.luma, i_yuv_data.luma)
                         + field_differs("chroma_blue", exp_px.chroma_blue,
                                         i_yuv_data.chroma_blue)
                         + field_differs("chroma_red", exp_px.chroma_red,
                                         i_yuv_data.chroma_red)
                         + field_differs("alpha_out", exp_px.alpha_out,
                                         i_yuv_data.alpha_out);
                    if (errs != 0)
                        o_fail_count <= o_fail_count + 1;
                end
            end
            o_pending <= expected_yuva_q.size();
        end
    end

endmodule

// ===== tb/rgba8_to_yuva444_10bit_bt709_unit_tb.sv =====
`timescale 1ns / 1ps

module rgba8_to_yuva444_10bit_bt709_unit_tb;
    import ryuv_pkg::*;

    localparam int FRACTION_BITS = 16;
    localparam int RANDOM_PIXELS = 1000;
    localparam int QUIET_TAIL    = 120;
    localparam int LONG_HOLD     = 200;
    localparam int STALL_LIMIT   = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int   idle_pct;
    bit   hold_now;
    int   fail_count;
    int   pending;
    int   stall_cycles;

    ryuv_stream_if #(.T_DATA(t_rgba)) pix_in_if ();
    ryuv_stream_if #(.T_DATA(t_yuva)) pix_out_if ();

    rgba8_to_yuva444_10bit_bt709_unit #(
        .FRACTION_BITS(FRACTION_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_in_if),
        .o_pix  (pix_out_if)
    );

    bt709_pixel_checker #(
        .FRACTION_BITS(FRACTION_BITS)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (pix_in_if.valid),
        .i_pix_ready (pix_in_if.ready),
        .i_pix_data  (pix_in_if.data),
        .i_yuv_valid (pix_out_if.valid),
        .i_yuv_ready (pix_out_if.ready),
        .i_yuv_data  (pix_out_if.data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_rgba rgba(int r, int g, int b, int a);
        t_rgba px;
        px.red     = 8'(r);
        px.green   = 8'(g);
        px.blue    = 8'(b);
        px.opacity = 8'(a);
        return px;
    endfunction

    // Uniform bytes half the time, otherwise at or near the range ends
    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(0, 3));
            3: return 8'($urandom_range(252, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one pixel, optionally after an idle burst; returns at the next falling edge
    task automatic send_pixel(input t_rgba px);
        if ($urandom_range(0, 99) < idle_pct) begin
            pix_in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        pix_in_if.valid <= 1'b1;
        pix_in_if.data  <= px;
        do
            @(posedge i_clk);
        while (!pix_in_if.ready);
        @(negedge i_clk);
    endtask

    // Output side: random stall bursts plus one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_now) begin
                pix_out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_now = 1'b0;
                pix_out_if.ready <= 1'b1;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                pix_out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                pix_out_if.ready <= 1'b1;
            end else begin
                pix_out_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_in_if.valid && pix_in_if.ready)
                || (pix_out_if.valid && pix_out_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        t_rgba corner_px[$];

        i_rst_n          = 1'b0;
        pix_in_if.valid  = 1'b0;
        pix_in_if.data   = '0;
        pix_out_if.ready = 1'b0;
        hold_now         = 1'b0;
        idle_pct         = 20;
        stall_cycles     = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: black, white, primaries, secondaries, alpha ends, bit patterns
        corner_px = '{rgba(0, 0, 0, 0), rgba(255, 255, 255, 255),
                      rgba(255, 0, 0, 128), rgba(0, 255, 0, 1),
                      rgba(0, 0, 255, 254), rgba(0, 255, 255, 127),
                      rgba(255, 0, 255, 64), rgba(255, 255, 0, 200),
                      rgba(8'h55, 8'hAA, 8'h55, 8'hAA), rgba(8'hAA, 8'h55, 8'hAA, 8'h55),
                      rgba(1, 1, 1, 2), rgba(254, 254, 254, 253),
                      rgba(128, 128, 128, 128), rgba(0, 0, 0, 255),
                      rgba(255, 255, 255, 0), rgba(16, 235, 16, 3),
                      rgba(235, 16, 235, 252)};
        foreach (corner_px[i])
            send_pixel(corner_px[i]);

        // Random pixels with varying idle density; quiet at the tail
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i % 125 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 50;
                endcase
            end
            if (i >= RANDOM_PIXELS - QUIET_TAIL)
                idle_pct = 0;
            if (i == 60)
                hold_now = 1'b1;
            send_pixel(rgba(random_byte(), random_byte(), random_byte(), random_byte()));
        end
        pix_in_if.valid <= 1'b0;

        // Drain, then wait on for any stray result before the verdict
        wait (pending == 0 && !hold_now);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ryuv_pkg.sv
rtl/ryuv_stream_if.sv
rtl/ryuv_lane.sv
rtl/rgba8_to_yuva444_10bit_bt709_unit.sv
tb/bt709_pixel_checker.sv
tb/rgba8_to_yuva444_10bit_bt709_unit_tb.sv
